>>> hw/rtl/mbpb_pkg.sv
// ----------------------------------------------------------------------------
// mbpb_pkg - shared types and constants for the page bitmap blitter
// Opcodes, configuration register indexes, beat payloads and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mbpb_pkg;

	localparam int DEF_BUFFER_COLUMNS = 128;
	localparam int DEF_BUFFER_PAGES   = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_HEIGHT = 2'd3;

	localparam logic [7:0] RST_BITMAP_WIDTH  = 8'd8;
	localparam logic [7:0] RST_BITMAP_HEIGHT = 8'd1;

	localparam logic [2:0] PIX_LAST = 3'd7;

	typedef enum logic [1:0] {
		OP_BITMAP = 2'd0,
		OP_FILL   = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] data_byte;
		logic [9:0] read_address;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       bitmap_done;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       pix_go;
		logic [2:0] pix_idx;
		logic       cur_adv;
		logic       rd_go;
		logic       sweep_go;
		logic       sweep_zero;
		logic       rsp_load;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic rsp_free;
	} status_t;

endpackage

>>> hw/rtl/mbpb_ram.sv
// ----------------------------------------------------------------------------
// mbpb_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/mbpb_ctrl.sv
// ----------------------------------------------------------------------------
// mbpb_ctrl - blitter sequencer
// Steps clearing and fill sweeps, the eight pixel slots of a bitmap byte,
// buffer reads and the hand-off of results to the output register.
// ----------------------------------------------------------------------------
module mbpb_ctrl import mbpb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  op_t     req_op,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_BLIT,
		ST_READ,
		ST_RESULT
	} state_t;

	state_t     state_q;
	logic [2:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					if (status.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) begin
						idx_q <= '0;
						case (req_op)
							OP_BITMAP: state_q <= ST_BLIT;
							OP_FILL:   state_q <= ST_FILL;
							OP_READ:   state_q <= ST_READ;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BLIT: begin
					if (idx_q == PIX_LAST) state_q <= ST_RESULT;
					else idx_q <= idx_q + 3'd1;
				end
				ST_READ: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (status.rsp_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		req_ready      = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && req_valid;
		cmd.pix_go     = (state_q == ST_BLIT);
		cmd.pix_idx    = idx_q;
		cmd.cur_adv    = (state_q == ST_BLIT) && (idx_q == PIX_LAST);
		cmd.rd_go      = (state_q == ST_READ);
		cmd.sweep_go   = (state_q == ST_CLEAR) || (state_q == ST_FILL);
		cmd.sweep_zero = (state_q == ST_CLEAR);
		cmd.rsp_load   = (state_q == ST_RESULT) && status.rsp_free;
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) && !status.rsp_free |=> (state_q == ST_RESULT))
		else $error("result dropped before output slot freed");

	a_sweep_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_go |-> !req_ready && !cmd.pix_go && !cmd.rd_go)
		else $error("sweep overlaps other buffer access");

endmodule

>>> hw/rtl/mbpb_dp.sv
// ----------------------------------------------------------------------------
// mbpb_dp - blitter datapath
// Configuration registers, bitmap cursors, pixel address generation, the
// read-modify-write stage into the frame store, sweep counter and output
// register.
// ----------------------------------------------------------------------------
module mbpb_dp import mbpb_pkg::*; #(
	parameter int BUFFER_COLUMNS = DEF_BUFFER_COLUMNS,
	parameter int BUFFER_PAGES   = DEF_BUFFER_PAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_t                  req,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	localparam int STORE_BYTES = BUFFER_COLUMNS * BUFFER_PAGES;
	localparam int PIXEL_ROWS  = BUFFER_PAGES * 8;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int FW          = ((AW > 9) ? AW : 9) + 1;
	localparam int RW          = ((AW > 10) ? AW : 10) + 1;

	logic [6:0] origin_x_q;
	logic [5:0] origin_y_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] row_q;
	logic [4:0] col_q;
	logic       done_q;

	logic [7:0]    data_q;
	logic          is_read_q;
	logic          rd_ok_q;
	logic [AW-1:0] rd_addr_q;
	logic          row_ok_q;
	logic [FW-1:0] page_base_q;
	logic [7:0]    mask_q;

	logic          wr_en_s1;
	logic [AW-1:0] wr_addr_s1;

	logic [AW-1:0] sweep_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [8:0]    y_cur;
	logic [7:0]    bx;
	logic [8:0]    x_pix;
	logic          hit;
	logic [FW-1:0] pix_addr_full;
	logic [AW-1:0] pix_addr;
	logic [8:0]    stride_full;
	logic [5:0]    stride;
	logic [5:0]    col_next;
	logic [8:0]    row_next;
	logic          row_end;
	logic          bm_end;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign y_cur         = {3'b0, origin_y_q} + {1'b0, row_q};
	assign bx            = {col_q, cmd.pix_idx};
	assign x_pix         = {2'b0, origin_x_q} + {1'b0, bx};
	assign hit           = cmd.pix_go && row_ok_q && data_q[PIX_LAST - cmd.pix_idx]
	                       && (bx < width_q) && (x_pix < 9'(BUFFER_COLUMNS));
	assign pix_addr_full = page_base_q + FW'(x_pix);
	assign pix_addr      = pix_addr_full[AW-1:0];

	assign stride_full = ({1'b0, width_q} + 9'd7) >> 3;
	assign stride      = (stride_full[5:0] == 6'd0) ? 6'd1 : stride_full[5:0];
	assign col_next    = {1'b0, col_q} + 6'd1;
	assign row_next    = {1'b0, row_q} + 9'd1;
	assign row_end     = (col_next >= stride);
	assign bm_end      = (row_next >= {1'b0, height_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= RST_BITMAP_WIDTH;
			height_q   <= RST_BITMAP_HEIGHT;
			row_q      <= '0;
			col_q      <= '0;
			done_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X:      origin_x_q <= cfg_data[6:0];
				CFG_ORIGIN_Y:      origin_y_q <= cfg_data[5:0];
				CFG_BITMAP_WIDTH:  width_q    <= cfg_data;
				CFG_BITMAP_HEIGHT: height_q   <= cfg_data;
				default:           width_q    <= width_q;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.cur_adv) begin
			if (row_end) begin
				col_q <= '0;
				if (bm_end) begin
					row_q  <= '0;
					done_q <= 1'b1;
				end else begin
					row_q  <= row_next[7:0];
					done_q <= 1'b0;
				end
			end else begin
				col_q  <= col_next[4:0];
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q      <= req.data_byte;
			is_read_q   <= (req.opcode == OP_READ);
			rd_ok_q     <= (RW'(req.read_address) < RW'(STORE_BYTES));
			rd_addr_q   <= AW'(RW'(req.read_address));
			row_ok_q    <= (y_cur < 9'(PIXEL_ROWS));
			page_base_q <= FW'(y_cur[8:3]) * FW'(BUFFER_COLUMNS);
			mask_q      <= 8'h01 << y_cur[2:0];
		end
		wr_addr_s1 <= pix_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1    <= 1'b0;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_en_s1 <= hit;
			if (cmd.sweep_go) begin
				sweep_q <= status.sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.read_data   <= (is_read_q && rd_ok_q) ? ram_rdata : 8'h00;
			rsp_q.bitmap_done <= !is_read_q && done_q;
		end
	end

	assign ram_we    = wr_en_s1 || cmd.sweep_go;
	assign ram_waddr = cmd.sweep_go ? sweep_q : wr_addr_s1;
	assign ram_wdata = cmd.sweep_go ? (cmd.sweep_zero ? 8'h00 : data_q)
	                                : (ram_rdata | mask_q);
	assign ram_re    = hit || (cmd.rd_go && rd_ok_q);
	assign ram_raddr = cmd.rd_go ? rd_addr_q : pix_addr;

	mbpb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign status.sweep_last = (sweep_q == AW'(STORE_BYTES - 1));
	assign status.rsp_free   = !rsp_valid_q || rsp_ready;
	assign rsp_valid         = rsp_valid_q;
	assign rsp               = rsp_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en_s1 && cmd.sweep_go))
		else $error("pixel write collides with sweep write");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> status.rsp_free)
		else $error("output register overwritten");

	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.cur_adv) && done_q |-> (row_q == 8'd0) && (col_q == 5'd0))
		else $error("cursors not rewound at end of bitmap");

endmodule

>>> hw/rtl/mono_bitmap_page_blitter.sv
// ----------------------------------------------------------------------------
// mono_bitmap_page_blitter - 1bpp bitmap blit into a page-organised buffer
// Places row-major bitmap bytes by OR into a page-laid-out frame store, fills
// the store with a pattern and reads single bytes back.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_ready    req_t  (opcode, data, addr)
//   rsp      out        rsp_valid / rsp_ready    rsp_t  (read_data, done)
//   cfg      in         cfg_we                   cfg_index, cfg_data
//
// Bitmap byte: one frame store read-modify-write per set pixel slot that
// falls inside the bitmap and the buffer. Fill: every store byte, one byte a
// cycle through the single write port.
// After reset a clearing pass zeroes the store; no beat is accepted
// meanwhile, configuration writes still are.
// A result beat waits in the output register; a stalled rsp holds the
// sequencer only when the next result is due.
// ----------------------------------------------------------------------------
module mono_bitmap_page_blitter import mbpb_pkg::*; #(
	parameter int BUFFER_COLUMNS = DEF_BUFFER_COLUMNS,
	parameter int BUFFER_PAGES   = DEF_BUFFER_PAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	mbpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.opcode),
		.req_ready(req_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mbpb_dp #(
		.BUFFER_COLUMNS(BUFFER_COLUMNS),
		.BUFFER_PAGES  (BUFFER_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.status   (status),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
